// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle property");

// consequent in the same cycle as the antecedent
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle property");

`endif

// ----- sv/bpc_pkg.sv -----
// ----------------------------------------------------------------------------
// bpc_pkg
// Types and constants of the bounded partition counter.
// ----------------------------------------------------------------------------
package bpc_pkg;

	localparam int MAX_SUM = 1023;
	localparam int DEPTH   = MAX_SUM + 1;
	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int FIELD_W = 10;
	localparam int COUNT_W = 32;

	typedef logic [ADDR_W-1:0]  addr_t;
	typedef logic [FIELD_W-1:0] field_t;
	typedef logic [COUNT_W-1:0] count_t;

	typedef struct packed {
		field_t max_face;
		field_t target_sum;
	} in_t;

	typedef struct packed {
		count_t way_count;
		logic   overflow;
	} out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_UPDATE,
		ST_FLUSH,
		ST_FETCH,
		ST_LOAD,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic  start;
		logic  clr_we;
		logic  clr_one;
		logic  upd;
		logic  load;
		logic  range_err;
		addr_t addr_a;
		addr_t addr_b;
	} ctl_t;

endpackage

// ----- sv/bpc_seq.sv -----
// ----------------------------------------------------------------------------
// bpc_seq
// Sequencer: clear sweep, face/sum iteration, result fetch and handshake.
// ----------------------------------------------------------------------------
module bpc_seq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          query_valid,
	input  bpc_pkg::in_t  query,
	output logic          query_stall,
	output logic          result_valid,
	input  logic          result_stall,
	output bpc_pkg::ctl_t ctl
);

	bpc_pkg::state_t state_q, state_d;
	bpc_pkg::field_t face_q, sum_q, kmin_q, s_q;
	logic            range_q;
	logic            accept;
	logic            range_in;
	logic            sum_end;
	bpc_pkg::field_t kmin_in;

	assign accept   = query_valid && (state_q == bpc_pkg::ST_IDLE);
	assign range_in = 32'(query.target_sum) > 32'(bpc_pkg::MAX_SUM);
	assign kmin_in  = (query.max_face < query.target_sum) ? query.max_face : query.target_sum;
	assign sum_end  = (sum_q == s_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			bpc_pkg::ST_IDLE: begin
				if (query_valid) begin
					state_d = range_in ? bpc_pkg::ST_LOAD : bpc_pkg::ST_CLEAR;
				end
			end
			bpc_pkg::ST_CLEAR: begin
				if (sum_end) begin
					state_d = (kmin_q == '0) ? bpc_pkg::ST_FLUSH : bpc_pkg::ST_UPDATE;
				end
			end
			bpc_pkg::ST_UPDATE: begin
				if (sum_end && (face_q == kmin_q)) begin
					state_d = bpc_pkg::ST_FLUSH;
				end
			end
			bpc_pkg::ST_FLUSH: state_d = bpc_pkg::ST_FETCH;
			bpc_pkg::ST_FETCH: state_d = bpc_pkg::ST_LOAD;
			bpc_pkg::ST_LOAD:  state_d = bpc_pkg::ST_DONE;
			bpc_pkg::ST_DONE: begin
				if (!result_stall) begin
					state_d = bpc_pkg::ST_IDLE;
				end
			end
			default: state_d = bpc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ctl           = '0;
		ctl.addr_a    = bpc_pkg::addr_t'(sum_q);
		ctl.addr_b    = bpc_pkg::addr_t'(sum_q - face_q);
		ctl.start     = accept;
		ctl.range_err = range_q;
		query_stall   = (state_q != bpc_pkg::ST_IDLE);
		result_valid  = (state_q == bpc_pkg::ST_DONE);
		case (state_q)
			bpc_pkg::ST_CLEAR: begin
				ctl.clr_we  = 1'b1;
				ctl.clr_one = (sum_q == '0);
			end
			bpc_pkg::ST_UPDATE: ctl.upd = 1'b1;
			bpc_pkg::ST_FETCH:  ctl.addr_a = bpc_pkg::addr_t'(s_q);
			bpc_pkg::ST_LOAD:   ctl.load = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bpc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s_q     <= query.target_sum;
			kmin_q  <= kmin_in;
			range_q <= range_in;
			sum_q   <= '0;
			face_q  <= bpc_pkg::field_t'(1);
		end else if (state_q == bpc_pkg::ST_CLEAR) begin
			sum_q <= sum_end ? bpc_pkg::field_t'(1) : sum_q + 1'b1;
		end else if (state_q == bpc_pkg::ST_UPDATE) begin
			if (sum_end) begin
				face_q <= face_q + 1'b1;
				sum_q  <= face_q + 1'b1;
			end else begin
				sum_q <= sum_q + 1'b1;
			end
		end
	end

endmodule

// ----- sv/bpc_datapath.sv -----
// ----------------------------------------------------------------------------
// bpc_datapath
// Count table, shared saturating adder with write forwarding, result register.
// ----------------------------------------------------------------------------
module bpc_datapath (
	input  logic          clk,
	input  logic          arst_n,
	input  bpc_pkg::ctl_t ctl,
	output bpc_pkg::out_t result
);

	bpc_pkg::count_t table_mem [bpc_pkg::DEPTH];

	bpc_pkg::count_t rd_a_q, rd_b_q;
	logic            upd_s1;
	bpc_pkg::addr_t  addr_a_s1, addr_b_s1;
	logic            wv_q;
	bpc_pkg::addr_t  wa_q;
	bpc_pkg::count_t wd_q;
	logic            ovf_q;
	bpc_pkg::out_t   result_q;

	bpc_pkg::count_t op_a, op_b, sat_sum;
	logic [bpc_pkg::COUNT_W:0] raw_sum;

	always_comb begin
		op_a    = (wv_q && (wa_q == addr_a_s1)) ? wd_q : rd_a_q;
		op_b    = (wv_q && (wa_q == addr_b_s1)) ? wd_q : rd_b_q;
		raw_sum = {1'b0, op_a} + {1'b0, op_b};
		sat_sum = raw_sum[bpc_pkg::COUNT_W] ? '1 : raw_sum[bpc_pkg::COUNT_W-1:0];
	end

	always_ff @(posedge clk) begin
		rd_a_q <= table_mem[ctl.addr_a];
		rd_b_q <= table_mem[ctl.addr_b];
		if (ctl.clr_we) begin
			table_mem[ctl.addr_a] <= ctl.clr_one ? bpc_pkg::count_t'(1) : '0;
		end else if (upd_s1) begin
			table_mem[addr_a_s1] <= sat_sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upd_s1 <= 1'b0;
			wv_q   <= 1'b0;
			ovf_q  <= 1'b0;
		end else begin
			upd_s1 <= ctl.upd;
			wv_q   <= upd_s1;
			if (ctl.start) begin
				ovf_q <= 1'b0;
			end else if (upd_s1 && raw_sum[bpc_pkg::COUNT_W]) begin
				ovf_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_a_s1 <= ctl.addr_a;
		addr_b_s1 <= ctl.addr_b;
		wa_q      <= addr_a_s1;
		wd_q      <= sat_sum;
		if (ctl.load) begin
			if (ctl.range_err) begin
				result_q.way_count <= '0;
				result_q.overflow  <= 1'b1;
			end else begin
				result_q.way_count <= rd_a_q;
				result_q.overflow  <= ovf_q;
			end
		end
	end

	assign result = result_q;

endmodule

// ----- sv/bounded_partition_counter_unit.sv -----
// ----------------------------------------------------------------------------
// bounded_partition_counter_unit
// Counts partitions of a target sum into parts no larger than a face limit.
//
//   channel  | direction | payload          | handshake
//   query    | in        | max_face, target | query_valid / query_stall
//   result   | out       | way_count, ovf   | result_valid / result_stall
//
// A query clears table entries 0 to s, then for each face i up to min(k,s)
// updates entries i to s, then passes the flush, fetch, load and done states
// to the result transfer, the shared adder doing one table read-add-write per cycle.
// A target above MAX_SUM goes straight to load. Reset clears only control state;
// the table is cleared per in-range query.
// The query side stalls from accept until the result transfer completes.
// ----------------------------------------------------------------------------
module bounded_partition_counter_unit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          query_valid,
	output logic          query_stall,
	input  bpc_pkg::in_t  query,
	output logic          result_valid,
	input  logic          result_stall,
	output bpc_pkg::out_t result
);

	bpc_pkg::ctl_t ctl;

	bpc_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.query_valid  (query_valid),
		.query        (query),
		.query_stall  (query_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.ctl          (ctl)
	);

	bpc_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.result (result)
	);

endmodule

// ----- sv/bpc_checker.sv -----
// ----------------------------------------------------------------------------
// bpc_checker
// Port-level checks of the bounded partition counter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bpc_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          query_valid,
	input logic          query_stall,
	input logic          result_valid,
	input logic          result_stall,
	input bpc_pkg::out_t result
);

	logic query_xfer;

	assign query_xfer = query_valid && !query_stall;

	`ASSERT_NEXT(a_hold_valid, clk, arst_n, result_valid && result_stall, result_valid)
	`ASSERT_NEXT(a_hold_data, clk, arst_n, result_valid && result_stall, $stable(result))
	`ASSERT_NEXT(a_no_early_result, clk, arst_n, query_xfer, !result_valid)
	`ASSERT_SAME(a_busy_with_result, clk, arst_n, result_valid, query_stall)
	`ASSERT_NEXT(a_ready_after_xfer, clk, arst_n, result_valid && !result_stall, !query_stall)

endmodule

bind bounded_partition_counter_unit bpc_checker u_chk (.*);
